[rtl/rgbfb_pkg.sv]
// shared constants, types and helpers for the rgb565 frame buffer
package rgbfb_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 320;

  // bus side widths
  localparam int ADDR_W  = 19;
  localparam int DATA_W  = 16;
  localparam int PIX_W   = ADDR_W - 1;
  localparam int COORD_W = 9;
  localparam int COLOR_W = 8;

  // store depth, capped at what the halfword index can reach
  localparam int PIX_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int MEM_DEPTH = (PIX_COUNT > (2 ** PIX_W)) ? (2 ** PIX_W) : PIX_COUNT;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [PIX_W:0] DEPTH_L = (PIX_W + 1)'(MEM_DEPTH);

  // row split by reciprocal multiply: y ~ (pix * RECIP) >> PIX_W, one correction step
  localparam int RECIP = (2 ** PIX_W) / SCREEN_WIDTH;
  localparam int REC_W = $clog2(RECIP + 1);
  localparam int W_W   = $clog2(SCREEN_WIDTH + 1);
  localparam int PROD_W = PIX_W + REC_W;
  localparam int YMUL_W = REC_W + W_W;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // write request towards the pixel store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  function automatic logic [DATA_W-1:0] swap16(logic [DATA_W-1:0] v, logic sw);
    logic [DATA_W-1:0] r;
    r = sw ? {v[7:0], v[15:8]} : v;
    return r;
  endfunction

endpackage

[rtl/rgb565_framebuffer_device_unit.sv]
// top level of the memory-mapped rgb565 frame buffer
//
// halfword frame buffer of SCREEN_WIDTH x SCREEN_HEIGHT pixels behind a start/busy
// command port. after reset the block sweeps the pixel store to zero, one entry per
// cycle, so busy is high and no command is taken until all SCREEN_WIDTH*SCREEN_HEIGHT
// (153600 at 480x320) entries are cleared. after that busy stays low and one access is
// taken every cycle. each access gives exactly one result, shown for one cycle under
// done_o; results leave in command order and the receiver has no way to hold them back.
// each access passes stage 1 (the store's registered read and the read-modify-write
// compare), stages 2 and 3 (beside the two-step row/column split of the pixel index by
// reciprocal multiplication) and the result registers. a write that hits the same
// pixel as the access right before it is forwarded, so back-to-back accesses to one
// pixel see each other. byte_swap may only be written while no access is in flight.
module rgb565_framebuffer_device_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command side
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation_i,
  input  logic [rgbfb_pkg::ADDR_W-1:0]         byte_address_i,
  input  logic [rgbfb_pkg::DATA_W-1:0]         write_data_i,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  // result side
  output logic                                 done_o,
  output logic [rgbfb_pkg::DATA_W-1:0]         read_data_o,
  output logic                                 status_o,
  output logic                                 pixel_changed_o,
  output logic [rgbfb_pkg::COORD_W-1:0]        pixel_x_o,
  output logic [rgbfb_pkg::COORD_W-1:0]        pixel_y_o,
  output logic [rgbfb_pkg::COLOR_W-1:0]        red_o,
  output logic [rgbfb_pkg::COLOR_W-1:0]        green_o,
  output logic [rgbfb_pkg::COLOR_W-1:0]        blue_o
);

  logic                          swap_q;
  logic                          clearing;
  logic                          accept;
  logic [rgbfb_pkg::PIX_W-1:0]   pix_in;
  logic [rgbfb_pkg::DATA_W-1:0]  rd_data;
  rgbfb_pkg::store_wr_t          store_wr;

  // stage 1: store read returns, compare and write back
  logic                          s1_valid_q;
  logic                          s1_write_q;
  logic                          s1_in_range_q;
  logic [rgbfb_pkg::PIX_W-1:0]   s1_pix_q;
  logic [rgbfb_pkg::DATA_W-1:0]  s1_stored_q;
  logic                          s1_fwd_q, s1_fwd_d;
  logic [rgbfb_pkg::DATA_W-1:0]  s1_fwd_data_q;
  logic [rgbfb_pkg::DATA_W-1:0]  s1_cur;
  logic                          s1_changed;
  logic [rgbfb_pkg::DATA_W-1:0]  s1_rdata;
  logic [rgbfb_pkg::COLOR_W-1:0] s1_red, s1_green, s1_blue;

  // stages 2 and 3: carry the result while the coordinates are worked out
  logic                          s2_valid_q, s3_valid_q;
  logic                          s2_status_q, s3_status_q;
  logic                          s2_changed_q, s3_changed_q;
  logic [rgbfb_pkg::DATA_W-1:0]  s2_rdata_q, s3_rdata_q;
  logic [rgbfb_pkg::COLOR_W-1:0] s2_red_q, s3_red_q;
  logic [rgbfb_pkg::COLOR_W-1:0] s2_green_q, s3_green_q;
  logic [rgbfb_pkg::COLOR_W-1:0] s2_blue_q, s3_blue_q;
  logic [rgbfb_pkg::COORD_W-1:0] s3_x, s3_y;

  // result registers
  logic                          done_q;
  logic [rgbfb_pkg::DATA_W-1:0]  rdata_q;
  logic                          status_q;
  logic                          changed_q;
  logic [rgbfb_pkg::COORD_W-1:0] x_q, y_q;
  logic [rgbfb_pkg::COLOR_W-1:0] red_q, green_q, blue_q;

  // busy only during the clearing sweep
  assign busy   = clearing;
  assign accept = start && !clearing;
  assign pix_in = byte_address_i[rgbfb_pkg::ADDR_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      swap_q <= cfg_wdata_i;
    end
  end

  rgbfb_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (pix_in[rgbfb_pkg::IDX_W-1:0]),
    .wr_i       (store_wr),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  // ---- stage 1 ----
  always_comb begin
    // the store read raced the previous write to the same pixel: take the forwarded word
    s1_cur     = s1_fwd_q ? s1_fwd_data_q : rd_data;
    s1_changed = s1_valid_q && s1_write_q && s1_in_range_q && (s1_cur != s1_stored_q);
    s1_rdata   = (s1_valid_q && !s1_write_q && s1_in_range_q)
                 ? rgbfb_pkg::swap16(s1_cur, swap_q) : '0;
    s1_red     = s1_changed ? {s1_stored_q[15:11], 3'b000} : '0;
    s1_green   = s1_changed ? {s1_stored_q[10:5], 2'b00} : '0;
    s1_blue    = s1_changed ? {s1_stored_q[4:0], 3'b000} : '0;
    s1_fwd_d   = s1_changed && (s1_pix_q == pix_in);
    store_wr.en   = s1_changed;
    store_wr.idx  = s1_pix_q[rgbfb_pkg::IDX_W-1:0];
    store_wr.data = s1_stored_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  // payload registers, qualified by the valid chain
  always_ff @(posedge clk_i) begin
    s1_write_q    <= (operation_i == rgbfb_pkg::OP_WRITE);
    s1_in_range_q <= ({1'b0, pix_in} < rgbfb_pkg::DEPTH_L);
    s1_pix_q      <= pix_in;
    s1_stored_q   <= rgbfb_pkg::swap16(write_data_i, swap_q);
    s1_fwd_q      <= s1_fwd_d;
    s1_fwd_data_q <= s1_stored_q;
  end

  // ---- row / column split, lines up with stage 3 ----
  rgbfb_coord u_coord (
    .clk_i (clk_i),
    .pix_i (s1_pix_q),
    .x_o   (s3_x),
    .y_o   (s3_y)
  );

  always_ff @(posedge clk_i) begin
    s2_status_q  <= s1_in_range_q ? rgbfb_pkg::STATUS_OK : rgbfb_pkg::STATUS_RANGE;
    s2_changed_q <= s1_changed;
    s2_rdata_q   <= s1_rdata;
    s2_red_q     <= s1_red;
    s2_green_q   <= s1_green;
    s2_blue_q    <= s1_blue;
    s3_status_q  <= s2_status_q;
    s3_changed_q <= s2_changed_q;
    s3_rdata_q   <= s2_rdata_q;
    s3_red_q     <= s2_red_q;
    s3_green_q   <= s2_green_q;
    s3_blue_q    <= s2_blue_q;
    // coordinates only reported for a pixel update
    rdata_q      <= s3_rdata_q;
    status_q     <= s3_status_q;
    changed_q    <= s3_changed_q;
    x_q          <= s3_changed_q ? s3_x : '0;
    y_q          <= s3_changed_q ? s3_y : '0;
    red_q        <= s3_red_q;
    green_q      <= s3_green_q;
    blue_q       <= s3_blue_q;
  end

  assign done_o          = done_q;
  assign read_data_o     = rdata_q;
  assign status_o        = status_q;
  assign pixel_changed_o = changed_q;
  assign pixel_x_o       = x_q;
  assign pixel_y_o       = y_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;

`ifndef ASSERT_OFF
  // no result can surface while the store is still being cleared
  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result during clearing sweep");

  // every taken command gives its result at done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result missing four cycles after command");

  // a pixel update only comes from an in-range access
  a_change_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pixel_changed_o) |-> (status_o == rgbfb_pkg::STATUS_OK))
    else $error("pixel update reported out of range");

  // without an update the pixel fields stay zero
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pixel_changed_o) |-> (pixel_x_o == '0 && pixel_y_o == '0 &&
      red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("pixel fields set without an update");

  // out-of-range accesses read back zero and change nothing
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == rgbfb_pkg::STATUS_RANGE) |-> (read_data_o == '0 && !pixel_changed_o))
    else $error("out-of-range access returned data");
`endif

endmodule

[rtl/rgbfb_store.sv]
// pixel store: one write and one registered read per cycle, cleared after reset
module rgbfb_store (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [rgbfb_pkg::IDX_W-1:0]          rd_idx_i,
  input  rgbfb_pkg::store_wr_t                 wr_i,
  output logic [rgbfb_pkg::DATA_W-1:0]         rd_data_o,
  output logic                                 clearing_o
);

  logic [rgbfb_pkg::DATA_W-1:0] mem_q [rgbfb_pkg::MEM_DEPTH];
  logic [rgbfb_pkg::DATA_W-1:0] rd_data_q;
  logic [rgbfb_pkg::IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic                         clearing_q, clearing_d;
  logic                         clr_last;

  assign clr_last = (clr_idx_q == rgbfb_pkg::IDX_W'(rgbfb_pkg::MEM_DEPTH - 1));

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_last) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

[rtl/rgbfb_coord.sv]
// two-stage split of a pixel index into column and row
module rgbfb_coord (
  input  logic                           clk_i,
  input  logic [rgbfb_pkg::PIX_W-1:0]    pix_i,
  output logic [rgbfb_pkg::COORD_W-1:0]  x_o,
  output logic [rgbfb_pkg::COORD_W-1:0]  y_o
);

  logic [rgbfb_pkg::PROD_W-1:0] prod_q;
  logic [rgbfb_pkg::PIX_W-1:0]  pix_a_q, pix_b_q;
  logic [rgbfb_pkg::REC_W-1:0]  y_est, y_est_q;
  logic [rgbfb_pkg::YMUL_W-1:0] ymul_q;
  logic [rgbfb_pkg::PIX_W-1:0]  rem;
  logic [rgbfb_pkg::REC_W-1:0]  y_fix;
  logic [rgbfb_pkg::PIX_W-1:0]  x_fix;
  logic                         over;

  // stage a: reciprocal product
  always_ff @(posedge clk_i) begin
    prod_q  <= rgbfb_pkg::PROD_W'(pix_i) * rgbfb_pkg::PROD_W'(rgbfb_pkg::RECIP);
    pix_a_q <= pix_i;
  end

  assign y_est = prod_q[rgbfb_pkg::PROD_W-1 -: rgbfb_pkg::REC_W];

  // stage b: back-multiply the row estimate
  always_ff @(posedge clk_i) begin
    y_est_q <= y_est;
    ymul_q  <= rgbfb_pkg::YMUL_W'(y_est) * rgbfb_pkg::YMUL_W'(rgbfb_pkg::SCREEN_WIDTH);
    pix_b_q <= pix_a_q;
  end

  // estimate is at most one row low
  always_comb begin
    rem   = pix_b_q - rgbfb_pkg::PIX_W'(ymul_q);
    over  = (rem >= rgbfb_pkg::PIX_W'(rgbfb_pkg::SCREEN_WIDTH));
    x_fix = over ? (rem - rgbfb_pkg::PIX_W'(rgbfb_pkg::SCREEN_WIDTH)) : rem;
    y_fix = over ? (y_est_q + 1'b1) : y_est_q;
  end

  assign x_o = x_fix[rgbfb_pkg::COORD_W-1:0];
  assign y_o = rgbfb_pkg::COORD_W'(y_fix);

endmodule

[tb/tb_top.sv]
// self-checking testbench for the rgb565 frame buffer unit
module tb_top;
  import rgbfb_pkg::*;

  // one result of the block, field by field
  typedef struct packed {
    logic [DATA_W-1:0]  rdata;
    logic               status;
    logic               changed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_result_t;

  // directed plan: an access, or a byte_swap write (value in data)
  typedef enum logic {
    ROW_ACC,
    ROW_SWAP
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    op_e                op;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic               fixed;   // expected result typed in below
    logic [DATA_W-1:0]  rd;
    logic               st;
    logic               ch;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } directed_row_t;

  localparam int LIMIT_CYCLES = 1000000;  // must outlast the clearing pass
  localparam int SETTLE_GAP   = 8;        // pipeline is four deep
  localparam int HOT_COUNT    = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                operation_i;
  logic [ADDR_W-1:0]   byte_address_i;
  logic [DATA_W-1:0]   write_data_i;
  logic                cfg_we_i;
  logic                cfg_wdata_i;
  logic                done_o;
  logic [DATA_W-1:0]   read_data_o;
  logic                status_o;
  logic                pixel_changed_o;
  logic [COORD_W-1:0]  pixel_x_o;
  logic [COORD_W-1:0]  pixel_y_o;
  logic [COLOR_W-1:0]  red_o;
  logic [COLOR_W-1:0]  green_o;
  logic [COLOR_W-1:0]  blue_o;

  rgb565_framebuffer_device_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .byte_address_i  (byte_address_i),
    .write_data_i    (write_data_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .read_data_o     (read_data_o),
    .status_o        (status_o),
    .pixel_changed_o (pixel_changed_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o)
  );

  // 10 unit period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pixel store as the testbench sees it, in store byte order
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] pixel_model [PIX_COUNT];
  logic              swap_model;

  pixel_result_t     pending_pixel_results [$];

  logic [ADDR_W-1:0] hot_addr [HOT_COUNT];
  logic [ADDR_W-1:0] prev_addr;
  int unsigned       idle_pct;

  int unsigned       mismatches;
  int unsigned       n_accesses;
  int unsigned       n_results;
  int unsigned       n_updates;
  int unsigned       n_range;

  // bus order <-> store order, the same swap both ways
  function automatic logic [DATA_W-1:0] to_bus(logic [DATA_W-1:0] v);
    return swap_model ? {v[7:0], v[15:8]} : v;
  endfunction

  // effect of one halfword access on the store, and the result it gives
  function automatic pixel_result_t framebuffer_access(op_e op, logic [ADDR_W-1:0] addr,
                                                        logic [DATA_W-1:0] bus);
    pixel_result_t     res;
    int unsigned       pix;
    logic [DATA_W-1:0] stored;
    res = '0;
    pix = 32'(addr >> 1);   // bit 0 of the byte address plays no part
    if (pix >= PIX_COUNT) begin
      res.status = STATUS_RANGE;   // out of range: no read data, nothing stored
    end else begin
      res.status = STATUS_OK;
      if (op == OP_READ) begin
        res.rdata = to_bus(pixel_model[pix]);
      end else begin
        stored = to_bus(bus);
        // only a real change to the pixel is reported
        if (pixel_model[pix] != stored) begin
          pixel_model[pix] = stored;
          res.changed = 1'b1;
          res.x       = COORD_W'(pix % SCREEN_WIDTH);
          res.y       = COORD_W'(pix / SCREEN_WIDTH);
          res.red     = {stored[15:11], 3'b000};
          res.green   = {stored[10:5], 2'b00};
          res.blue    = {stored[4:0], 3'b000};
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: every strobed result against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", n_results, what);
    mismatches++;
  endtask

  task automatic match_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // outputs are sampled at the edge that accepts them, before any update lands
  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    if (rst_ni && done_o) begin
      if (pending_pixel_results.size() == 0) begin
        report_mismatch("result strobed with nothing outstanding");
      end else begin
        want = pending_pixel_results.pop_front();
        match_field("read_data", read_data_o, want.rdata);
        match_field("status", status_o, want.status);
        match_field("pixel_changed", pixel_changed_o, want.changed);
        match_field("pixel_x", pixel_x_o, want.x);
        match_field("pixel_y", pixel_y_o, want.y);
        match_field("red", red_o, want.red);
        match_field("green", green_o, want.green);
        match_field("blue", blue_o, want.blue);
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // one transfer: hold start until the edge where busy is low, then predict;
  // start is left high so back-to-back transfers never drop it in between
  task automatic send_access(op_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                             bit use_fixed, pixel_result_t fixed_res, bit idle_on);
    pixel_result_t predicted;
    start          <= 1'b1;
    operation_i    <= op;
    byte_address_i <= addr;
    write_data_i   <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = framebuffer_access(op, addr, data);
    pending_pixel_results.push_back(use_fixed ? fixed_res : predicted);
    n_accesses++;
    if (predicted.changed) n_updates++;
    if (predicted.status == STATUS_RANGE) n_range++;
    prev_addr = addr;
    // sender gap of random length
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixel_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  // byte_swap is only touched with the pipeline empty
  task automatic set_byte_swap(logic v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    swap_model  = v;
  endtask

  // random accesses: mostly a small set of hot pixels so reads see earlier
  // writes, rewrites of the same value happen, and same-pixel accesses land
  // back to back; the rest spread over the pixel range or the whole address space
  task automatic random_phase(int count, bit idle_on);
    int unsigned       sel;
    int unsigned       pix;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < 10)
        addr = prev_addr ^ ADDR_W'($urandom_range(0, 1));
      else if (sel < 65)
        addr = hot_addr[$urandom_range(0, HOT_COUNT - 1)] | ADDR_W'($urandom_range(0, 1));
      else if (sel < 85)
        addr = ADDR_W'($urandom_range(0, 2 * PIX_COUNT - 1));
      else
        addr = ADDR_W'($urandom());
      op  = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      pix = 32'(addr >> 1);
      if (op == OP_WRITE && pix < PIX_COUNT && $urandom_range(0, 3) == 0)
        data = to_bus(pixel_model[pix]);   // rewrite of the value already there
      else if ($urandom_range(0, 7) == 0)
        data = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      else
        data = DATA_W'($urandom());
      send_access(op, addr, data, 1'b0, '0, idle_on);
    end
  endtask

  // directed part; expected values typed in where they are obvious
  directed_row_t directed_plan [24] = '{
    '{ROW_SWAP, OP_READ,  0,      0,      0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    // fresh store reads as zero, out of range accesses give status only
    '{ROW_ACC,  OP_READ,  0,      0,      1, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  307198, 0,      1, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  307200, 0,      1, 0,      STATUS_RANGE, 0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  524287, 'hffff, 1, 0,      STATUS_RANGE, 0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 524286, 'hffff, 1, 0,      STATUS_RANGE, 0, 0,   0,   0,    0,    0},
    // writing the value already stored is silent; a new value is reported
    '{ROW_ACC,  OP_WRITE, 0,      0,      1, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 0,      'hffff, 1, 0,      STATUS_OK,    1, 0,   0,   'hf8, 'hfc, 'hf8},
    '{ROW_ACC,  OP_WRITE, 1,      'hffff, 1, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  1,      0,      1, 'hffff, STATUS_OK,    0, 0,   0,   0,    0,    0},
    // corner pixels
    '{ROW_ACC,  OP_WRITE, 307199, 'hf800, 1, 0,      STATUS_OK,    1, 479, 319, 'hf8, 0,    0},
    '{ROW_ACC,  OP_READ,  307198, 0,      1, 'hf800, STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 958,    'h07e0, 1, 0,      STATUS_OK,    1, 479, 0,   0,    'hfc, 0},
    '{ROW_ACC,  OP_WRITE, 960,    'h001f, 1, 0,      STATUS_OK,    1, 0,   1,   0,    0,    'hf8},
    // same pixel in a row, through the forwarding path unless an idle gap falls between
    '{ROW_ACC,  OP_WRITE, 'h1234, 'ha5c3, 0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 'h1235, 'h5a3c, 0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  'h1234, 0,      0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    // byte swap on: bus and store orders differ
    '{ROW_SWAP, OP_READ,  0,      1,      0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_READ,  958,    0,      1, 'he007, STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 2,      'h00f8, 1, 0,      STATUS_OK,    1, 1,   0,   'hf8, 0,    0},
    '{ROW_ACC,  OP_READ,  2,      0,      1, 'h00f8, STATUS_OK,    0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 307200, 'h1234, 1, 0,      STATUS_RANGE, 0, 0,   0,   0,    0,    0},
    '{ROW_ACC,  OP_WRITE, 'h40000, 'h8000, 1, 0,     STATUS_OK,    1, 32,  273, 0,    'h10, 0},
    '{ROW_SWAP, OP_READ,  0,      0,      0, 0,      STATUS_OK,    0, 0,   0,   0,    0,    0}
  };

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    directed_row_t row;
    pixel_result_t fixed_res;
    // every input known from time zero
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = 1'b0;
    byte_address_i = '0;
    write_data_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    swap_model     = 1'b0;
    idle_pct       = 20;
    prev_addr      = '0;
    mismatches     = 0;
    n_accesses     = 0;
    n_results      = 0;
    n_updates      = 0;
    n_range        = 0;
    for (int p = 0; p < PIX_COUNT; p++) pixel_model[p] = '0;

    // hot pixels: three corners and the start of the second row, plus random ones
    hot_addr[0] = '0;
    hot_addr[1] = ADDR_W'(2 * (PIX_COUNT - 1));
    hot_addr[2] = ADDR_W'(2 * (SCREEN_WIDTH - 1));
    hot_addr[3] = ADDR_W'(2 * SCREEN_WIDTH);
    for (int h = 4; h < HOT_COUNT; h++)
      hot_addr[h] = ADDR_W'(2 * $urandom_range(0, PIX_COUNT - 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block clears its store after reset with busy high
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_SWAP) begin
        set_byte_swap(row.data[0]);
      end else begin
        fixed_res = '{row.rd, row.st, row.ch, row.x, row.y, row.r, row.g, row.b};
        send_access(row.op, row.addr, row.data, row.fixed, fixed_res, 1'b1);
      end
    end

    // random part over both swap settings, gaps switched off at the very end
    set_byte_swap(1'b1);
    random_phase(150, 1'b1);
    set_byte_swap(1'b0);
    random_phase(175, 1'b1);
    set_byte_swap(1'b1);
    random_phase(175, 1'b1);
    set_byte_swap(1'b0);
    random_phase(100, 1'b1);
    random_phase(100, 1'b0);

    drain_results();

    $display("covered %0d accesses (%0d pixel updates, %0d out of range), %0d results seen",
             n_accesses, n_updates, n_range, n_results);
    $display("byte swap run both off and on, idle gaps and back-to-back transfers mixed");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog: a stuck handshake or missing result ends the run here
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
